>>> design/rhbm_pkg.sv
package rhbm_pkg;

	localparam int KEY_W      = 64;
	localparam int HASH_W     = 60;
	localparam int CNT_W      = 40;
	localparam int DVS_W      = 9;
	localparam int REM_W      = 8;
	localparam int DIV_STAGES = 8;
	localparam int DIV_STEPS  = KEY_W / DIV_STAGES;

	// configuration register indexes
	localparam logic [2:0] REG_HASH_SEED         = 3'd0;
	localparam logic [2:0] REG_HASH_BYPASS       = 3'd1;
	localparam logic [2:0] REG_LOG_BASE_ARCS     = 3'd2;
	localparam logic [2:0] REG_LONG_ARC_COUNT    = 3'd3;
	localparam logic [2:0] REG_SHORT_GROUP_COUNT = 3'd4;
	localparam logic [2:0] REG_SHORT_ARC_COUNT   = 3'd5;
	localparam logic [2:0] REG_ARC_SIZE          = 3'd6;
	localparam logic [2:0] REG_GROUP_MULTIPLIER  = 3'd7;

	// layout as the datapath sees it: lg already clamped, cs never zero
	typedef struct packed {
		logic [63:0] seed;
		logic        bypass;
		logic [2:0]  lg;
		logic [31:0] long_arcs;
		logic [31:0] short_groups;
		logic [31:0] short_arcs;
		logic [7:0]  cs;
		logic [31:0] groups;
	} cfg_t;

	// what rides along the divider besides dividend and divisor
	typedef struct packed {
		logic       direct;
		logic [7:0] dval;
		logic       wide;
	} side_t;

endpackage

>>> design/round_hash_bucket_map_core.sv
// Maps each 64-bit key to a bucket by round hashing: optional seeded mixing to a
// 60-bit hash, multiply-high scaling into an arc index under the arc layout held
// in the configuration registers, then a divide by the arc size and a
// trailing-zero shift. One key is taken every cycle unless the output is held, and
// each key passes 5 hashing and scaling stages, an 8-stage divider retiring 8
// quotient bits per stage, and 3 finishing stages. The whole pipeline holds while
// a finished bucket waits on bucket_ready. Configuration writes are taken at
// once; write them only while no key is in flight.
module round_hash_bucket_map_core #(
	parameter int MAX_BASE_ARCS = 128,
	parameter int BUCKET_BITS   = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     key_valid,
	output logic                     key_ready,
	input  logic [63:0]              key,
	output logic                     bucket_valid,
	input  logic                     bucket_ready,
	output logic [BUCKET_BITS-1:0]   bucket,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [63:0]              cfg_data
);
	import rhbm_pkg::*;

	localparam int MAX_LOG = $clog2(MAX_BASE_ARCS + 1) - 1;

	logic [63:0] seed_q;
	logic        bypass_q;
	logic [2:0]  lg_q;
	logic [31:0] long_q, sgc_q, short_q, groups_q;
	logic [7:0]  cs_q;
	cfg_t        cfg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= '0;
			bypass_q <= 1'b0;
			lg_q     <= '0;
			long_q   <= 32'd1;
			sgc_q    <= '0;
			short_q  <= '0;
			cs_q     <= 8'd1;
			groups_q <= 32'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HASH_SEED:         seed_q   <= cfg_data;
				REG_HASH_BYPASS:       bypass_q <= cfg_data[0];
				REG_LOG_BASE_ARCS: begin
					// base count limited to the largest power of two that fits
					if (int'(cfg_data[2:0]) > MAX_LOG) lg_q <= 3'(MAX_LOG);
					else lg_q <= cfg_data[2:0];
				end
				REG_LONG_ARC_COUNT:    long_q   <= cfg_data[31:0];
				REG_SHORT_GROUP_COUNT: sgc_q    <= cfg_data[31:0];
				REG_SHORT_ARC_COUNT:   short_q  <= cfg_data[31:0];
				REG_ARC_SIZE:          cs_q     <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
				REG_GROUP_MULTIPLIER:  groups_q <= cfg_data[31:0];
			endcase
		end
	end

	always_comb begin
		cfg.seed         = seed_q;
		cfg.bypass       = bypass_q;
		cfg.lg           = lg_q;
		cfg.long_arcs    = long_q;
		cfg.short_groups = sgc_q;
		cfg.short_arcs   = short_q;
		cfg.cs           = cs_q;
		cfg.groups       = groups_q;
	end

	logic en;
	assign en        = !bucket_valid || bucket_ready;
	assign key_ready = en;

	logic             f_vld;
	logic [KEY_W-1:0] f_dvd;
	logic [DVS_W-1:0] f_dvs;
	side_t            f_side;

	rhbm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (key_valid),
		.key     (key),
		.cfg     (cfg),
		.out_vld (f_vld),
		.dvd     (f_dvd),
		.dvs     (f_dvs),
		.side    (f_side)
	);

	logic             d_vld;
	logic [KEY_W-1:0] d_quo;
	logic [REM_W-1:0] d_rem;
	side_t            d_side;

	rhbm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (f_vld),
		.in_dvd   (f_dvd),
		.in_dvs   (f_dvs),
		.in_side  (f_side),
		.out_vld  (d_vld),
		.out_quo  (d_quo),
		.out_rem  (d_rem),
		.out_side (d_side)
	);

	rhbm_back #(
		.BUCKET_BITS (BUCKET_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (d_vld),
		.quo     (d_quo),
		.rem     (d_rem),
		.side    (d_side),
		.cfg     (cfg),
		.out_vld (bucket_valid),
		.bucket  (bucket)
	);

endmodule

>>> design/rhbm_front.sv
module rhbm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic [rhbm_pkg::KEY_W-1:0]     key,
	input  rhbm_pkg::cfg_t                 cfg,
	output logic                           out_vld,
	output logic [rhbm_pkg::KEY_W-1:0]     dvd,
	output logic [rhbm_pkg::DVS_W-1:0]     dvs,
	output rhbm_pkg::side_t                side
);
	import rhbm_pkg::*;

	typedef struct packed {
		logic [35:0] hh;
		logic [59:0] hl;
		logic [39:0] lh;
		logic [63:0] ll;
	} scale_pp_t;

	function automatic scale_pp_t scale_prod(input logic [CNT_W-1:0] cnt,
			input logic [HASH_W-1:0] h);
		scale_pp_t p;
		p.hh = 36'(h[59:32]) * 36'(cnt[39:32]);
		p.hl = 60'(h[59:32]) * 60'(cnt[31:0]);
		p.lh = 40'(h[31:0]) * 40'(cnt[39:32]);
		p.ll = 64'(h[31:0]) * 64'(cnt[31:0]);
		return p;
	endfunction

	function automatic logic [38:0] scale_sum(input scale_pp_t p);
		logic [60:0] mid;
		mid = 61'(p.hl) + 61'(p.lh) + 61'(p.ll[63:32]);
		return 39'({p.hh, 2'b00}) + 39'(mid >> 28);
	endfunction

	logic [7:0] base;
	assign base = 8'd1 << cfg.lg;

	// s1: key mixing and arc-size times groups
	logic [63:0] t1, t0, t1r, mixed;
	logic [HASH_W-1:0] h_s1;
	logic [CNT_W-1:0]  cmul_s1;
	logic              vld_s1;

	always_comb begin
		t1    = cfg.seed ^ key;
		t0    = {key[8:0], key[63:9]} ^ t1 ^ {t1[49:0], 14'b0};
		t1r   = {t1[27:0], t1[63:28]};
		mixed = t0 + t1r;
	end

	// s2: partial products of the three scalings
	logic [32:0]      total;
	logic [CNT_W-1:0] cnt_b;
	scale_pp_t        pa_s2, pb_s2, pc_s2;
	logic             lt_s2, vld_s2;

	assign total = 33'(cfg.long_arcs) + 33'(cfg.short_arcs);
	assign cnt_b = cmul_s1 + CNT_W'(cfg.groups);

	// s3: scaled arc candidates
	logic [38:0] sa_s3, sb_s3, sc_s3;
	logic        lt_s3, vld_s3;

	// s4: selected arc
	logic [CNT_W-1:0] arc_s4;
	logic [CNT_W-1:0] arc_sel;
	logic             vld_s4;

	always_comb begin
		if (lt_s3) begin
			arc_sel = CNT_W'(sa_s3);
		end else if (CNT_W'(sb_s3) >= CNT_W'(cfg.short_arcs)) begin
			arc_sel = CNT_W'(sc_s3) + CNT_W'(cfg.short_groups);
		end else begin
			arc_sel = CNT_W'(sb_s3);
		end
	end

	// s5: divider operands
	logic              in_short;
	logic [KEY_W-1:0]  dvd_s5;
	logic [DVS_W-1:0]  dvs_s5, dvs_nx;
	side_t             side_s5, side_nx;
	logic              vld_s5;

	always_comb begin
		in_short       = CNT_W'(cfg.short_arcs) > arc_s4;
		dvs_nx         = DVS_W'(cfg.cs) + DVS_W'(in_short);
		side_nx.direct = arc_s4 < CNT_W'(base);
		side_nx.dval   = arc_s4[7:0];
		side_nx.wide   = dvs_nx > DVS_W'(base);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1    <= cfg.bypass ? key[HASH_W-1:0] : mixed[HASH_W-1:0];
			cmul_s1 <= CNT_W'(cfg.cs) * CNT_W'(cfg.groups);
			pa_s2   <= scale_prod(CNT_W'(total), h_s1);
			pb_s2   <= scale_prod(cnt_b, h_s1);
			pc_s2   <= scale_prod(cmul_s1, h_s1);
			lt_s2   <= total < 33'(base);
			sa_s3   <= scale_sum(pa_s2);
			sb_s3   <= scale_sum(pb_s2);
			sc_s3   <= scale_sum(pc_s2);
			lt_s3   <= lt_s2;
			arc_s4  <= arc_sel;
			// long arcs drop the short group offset, wrapping below zero
			dvd_s5  <= in_short ? KEY_W'(arc_s4) : KEY_W'(arc_s4) - KEY_W'(cfg.short_groups);
			dvs_s5  <= dvs_nx;
			side_s5 <= side_nx;
		end
	end

	assign out_vld = vld_s5;
	assign dvd     = dvd_s5;
	assign dvs     = dvs_s5;
	assign side    = side_s5;

endmodule

>>> design/rhbm_div.sv
module rhbm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic [rhbm_pkg::KEY_W-1:0]     in_dvd,
	input  logic [rhbm_pkg::DVS_W-1:0]     in_dvs,
	input  rhbm_pkg::side_t                in_side,
	output logic                           out_vld,
	output logic [rhbm_pkg::KEY_W-1:0]     out_quo,
	output logic [rhbm_pkg::REM_W-1:0]     out_rem,
	output rhbm_pkg::side_t                out_side
);
	import rhbm_pkg::*;

	// restoring division, DIV_STEPS quotient bits per stage
	logic             vld_s  [DIV_STAGES];
	logic [KEY_W-1:0] work_s [DIV_STAGES];
	logic [REM_W-1:0] rem_s  [DIV_STAGES];
	logic [DVS_W-1:0] dvs_s  [DIV_STAGES];
	side_t            side_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic             v_in;
		logic [KEY_W-1:0] w_in, w_nx;
		logic [REM_W-1:0] r_in, r_nx;
		logic [DVS_W-1:0] d_in;
		side_t            s_in;

		if (g == 0) begin : g_first
			assign v_in = in_vld;
			assign w_in = in_dvd;
			assign r_in = '0;
			assign d_in = in_dvs;
			assign s_in = in_side;
		end else begin : g_next
			assign v_in = vld_s[g-1];
			assign w_in = work_s[g-1];
			assign r_in = rem_s[g-1];
			assign d_in = dvs_s[g-1];
			assign s_in = side_s[g-1];
		end

		always_comb begin
			logic [DVS_W-1:0] t;
			w_nx = w_in;
			r_nx = r_in;
			for (int i = 0; i < DIV_STEPS; i++) begin
				t = {r_nx, w_nx[KEY_W-1]};
				if (t >= d_in) begin
					r_nx = REM_W'(t - d_in);
					w_nx = {w_nx[KEY_W-2:0], 1'b1};
				end else begin
					r_nx = t[REM_W-1:0];
					w_nx = {w_nx[KEY_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				work_s[g] <= w_nx;
				rem_s[g]  <= r_nx;
				dvs_s[g]  <= d_in;
				side_s[g] <= s_in;
			end
		end
	end

	assign out_vld  = vld_s[DIV_STAGES-1];
	assign out_quo  = work_s[DIV_STAGES-1];
	assign out_rem  = rem_s[DIV_STAGES-1];
	assign out_side = side_s[DIV_STAGES-1];

endmodule

>>> design/rhbm_back.sv
module rhbm_back #(
	parameter int BUCKET_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic [rhbm_pkg::KEY_W-1:0]     quo,
	input  logic [rhbm_pkg::REM_W-1:0]     rem,
	input  rhbm_pkg::side_t                side,
	input  rhbm_pkg::cfg_t                 cfg,
	output logic                           out_vld,
	output logic [BUCKET_BITS-1:0]         bucket
);
	import rhbm_pkg::*;

	function automatic logic [6:0] tz64(input logic [63:0] v);
		logic [63:0] lsb;
		logic [6:0]  n;
		lsb = v & (~v + 64'd1);
		n   = '0;
		for (int i = 0; i < 64; i++) begin
			if (lsb[i]) begin
				n = n | 7'(i);
			end
		end
		if (v == '0) begin
			n = 7'd64;
		end
		return n;
	endfunction

	logic [7:0] base;
	assign base = 8'd1 << cfg.lg;

	// s1: split group when the arc size exceeds the base count
	logic [63:0] grp_nx, grp_s1;
	logic [8:0]  pos_nx, pos_s1;
	logic [32:0] ig_nx, ig_s1;
	side_t       side_s1;
	logic        vld_s1;

	always_comb begin
		if (side.wide) begin
			grp_nx = {quo[62:0], 1'b0} + 64'(9'(rem) >> cfg.lg);
			pos_nx = 9'(rem) & 9'(base - 8'd1);
			ig_nx  = {cfg.groups, 1'b0};
		end else begin
			grp_nx = quo;
			pos_nx = 9'(rem);
			ig_nx  = 33'(cfg.groups);
		end
	end

	// s2: product and trailing-zero count
	logic [41:0] prod_s2;
	logic [63:0] grp_s2;
	logic [6:0]  dist_s2;
	side_t       side_s2;
	logic        vld_s2;

	// s3: final shift
	logic [63:0]            sum, shifted;
	logic [BUCKET_BITS-1:0] bucket_s3, bucket_nx;
	logic                   vld_s3;

	always_comb begin
		sum     = 64'(prod_s2) + grp_s2;
		shifted = sum >> (dist_s2 + 7'd1);
		if (side_s2.direct) begin
			bucket_nx = BUCKET_BITS'(side_s2.dval);
		end else if (dist_s2 >= 7'd63) begin
			bucket_nx = '0;
		end else begin
			bucket_nx = shifted[BUCKET_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s1    <= grp_nx;
			pos_s1    <= pos_nx;
			ig_s1     <= ig_nx;
			side_s1   <= side;
			prod_s2   <= 42'(9'(base) + pos_s1) * 42'(ig_s1);
			grp_s2    <= grp_s1;
			dist_s2   <= tz64(grp_s1);
			side_s2   <= side_s1;
			bucket_s3 <= bucket_nx;
		end
	end

	assign out_vld = vld_s3;
	assign bucket  = bucket_s3;

endmodule
